/* src/pft_pkg.sv */
// Shared constants, codes and types for the pair frequency table.
package pft_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W      = $clog2(MAX_ENTRIES + 1);

  // Count ceiling
  localparam logic [15:0] HIT_MAX = 16'hFFFF;

  // Action decode: the high bit alone selects clear
  localparam logic [1:0] ACT_READ      = 2'd1;
  localparam int         ACT_CLEAR_BIT = 1;

  typedef enum logic [2:0] {
    ST_INCREMENTED = 3'd0,
    ST_SATURATED   = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_FULL        = 3'd3,
    ST_READ_OK     = 3'd4,
    ST_READ_RANGE  = 3'd5,
    ST_CLEARED     = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  key_first;
    logic [7:0]  key_second;
    logic [15:0] hits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SEARCH,
    FSM_DONE
  } fsm_t;

endpackage

/* src/pft_ram.sv */
// Generic single-port RAM with registered read data.
module pft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read on the shared port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pair_frequency_table_top.sv */
// Pair frequency table: top level with search sequencer and result register.
//
// Counts ordered key pairs in a table of MAX_ENTRIES slots held in one
// single-port RAM. A count beat walks the slots in use one per cycle
// (read issued each cycle, compared the next), then bumps the matching
// count, appends a new slot, or drops the event when the table is full.
// Its result is parked in the output register once that walk through
// the RAM port ends. A read beat's result is parked after one RAM read,
// a clear beat's without a RAM access. One beat is worked at a time;
// in_ready rises together with out_valid when the result is parked, so
// the next beat can be taken while the result still waits on out_ready.
// A stalled output holds the block until the output register frees. No
// clearing pass is needed after reset.
module pair_frequency_table_top
  import pft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_key_first,
  input  logic [7:0]  in_key_second,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_pair_first,
  output logic [7:0]  out_pair_second,
  output logic [15:0] out_pair_count,
  output logic [6:0]  out_entries_used
);

  // Control state
  fsm_t              state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [USED_W-1:0] issue_idx_r, issue_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic [ADDR_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [7:0]        key_first_r, key_first_nxt;
  logic [7:0]        key_second_r, key_second_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [7:0]        res_first_r, res_first_nxt;
  logic [7:0]        res_second_r, res_second_nxt;
  logic [15:0]       res_count_r, res_count_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [7:0]        out_first_r, out_first_nxt;
  logic [7:0]        out_second_r, out_second_nxt;
  logic [15:0]       out_count_r, out_count_nxt;
  logic [6:0]        out_used_r, out_used_nxt;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Decode and search conditions
  logic              in_fire;
  logic              act_clear;
  logic              act_read;
  logic              read_in_range;
  logic              issue_more;
  logic              srch_hit;
  logic              srch_miss;
  logic              room;
  logic              hit_sat;
  logic [15:0]       hit_next;
  logic              out_free;
  logic [USED_W+6:0] used_ext;

  assign in_ready      = (state_r == FSM_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign act_clear     = in_action[ACT_CLEAR_BIT];
  assign act_read      = (in_action == ACT_READ);
  assign read_in_range = (9'(in_entry_index) < 9'(used_r));

  assign ram_rdata  = entry_t'(ram_rdata_raw);
  assign issue_more = (issue_idx_r < used_r) && !srch_hit;
  assign srch_hit   = pend_r && (ram_rdata.key_first == key_first_r)
                      && (ram_rdata.key_second == key_second_r);
  assign srch_miss  = !pend_r && !(issue_idx_r < used_r);
  assign room       = (used_r < USED_W'(MAX_ENTRIES));
  assign hit_sat    = (ram_rdata.hits == HIT_MAX);
  assign hit_next   = hit_sat ? ram_rdata.hits : (ram_rdata.hits + 16'd1);
  assign out_free   = !out_valid_r || out_ready;
  assign used_ext   = {7'd0, used_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          if (act_clear) begin
            state_nxt = FSM_DONE;
          end else if (act_read) begin
            state_nxt = read_in_range ? FSM_READ : FSM_DONE;
          end else begin
            state_nxt = FSM_SEARCH;
          end
        end
      end
      FSM_READ: begin
        state_nxt = FSM_DONE;
      end
      FSM_SEARCH: begin
        if (srch_hit || srch_miss) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Drive the RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire && !act_clear && act_read && read_in_range) begin
          ram_re   = 1'b1;
          ram_addr = in_entry_index[ADDR_W-1:0];
        end
      end
      FSM_SEARCH: begin
        if (srch_hit) begin
          ram_we    = 1'b1;
          ram_addr  = pend_idx_r;
          ram_wdata = '{key_first: key_first_r, key_second: key_second_r,
                        hits: hit_next};
        end else if (srch_miss && room) begin
          ram_we    = 1'b1;
          ram_addr  = used_r[ADDR_W-1:0];
          ram_wdata = '{key_first: key_first_r, key_second: key_second_r,
                        hits: 16'd1};
        end else if (issue_more) begin
          ram_re   = 1'b1;
          ram_addr = issue_idx_r[ADDR_W-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath and result registers
  always_comb begin
    used_nxt       = used_r;
    issue_idx_nxt  = issue_idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    key_first_nxt  = key_first_r;
    key_second_nxt = key_second_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_count_nxt  = out_count_r;
    out_used_nxt   = out_used_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          key_first_nxt  = in_key_first;
          key_second_nxt = in_key_second;
          issue_idx_nxt  = '0;
          pend_nxt       = 1'b0;
          res_first_nxt  = 8'd0;
          res_second_nxt = 8'd0;
          res_count_nxt  = 16'd0;
          if (act_clear) begin
            used_nxt       = '0;
            res_status_nxt = ST_CLEARED;
          end else if (act_read) begin
            res_status_nxt = ST_READ_RANGE;
          end
        end
      end
      FSM_READ: begin
        res_status_nxt = ST_READ_OK;
        res_first_nxt  = ram_rdata.key_first;
        res_second_nxt = ram_rdata.key_second;
        res_count_nxt  = ram_rdata.hits;
      end
      FSM_SEARCH: begin
        // Advance the walk: the read issued now is compared next cycle
        pend_nxt     = issue_more;
        pend_idx_nxt = issue_idx_r[ADDR_W-1:0];
        if (issue_more) begin
          issue_idx_nxt = USED_W'(issue_idx_r + 1'b1);
        end
        if (srch_hit) begin
          res_status_nxt = hit_sat ? ST_SATURATED : ST_INCREMENTED;
          res_count_nxt  = hit_next;
        end else if (srch_miss) begin
          if (room) begin
            used_nxt       = USED_W'(used_r + 1'b1);
            res_status_nxt = ST_INSERTED;
            res_count_nxt  = 16'd1;
          end else begin
            res_status_nxt = ST_FULL;
          end
        end
      end
      FSM_DONE: begin
        // Park the result once the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_first_nxt  = res_first_r;
          out_second_nxt = res_second_r;
          out_count_nxt  = res_count_r;
          out_used_nxt   = used_ext[6:0];
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      used_r      <= '0;
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      issue_idx_r <= issue_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    key_first_r  <= key_first_nxt;
    key_second_r <= key_second_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_count_r  <= out_count_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Slot storage
  pft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_slots (
    .clk   (clk),
    .wr_en (ram_we),
    .rd_en (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata_raw)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_pair_first   = out_first_r;
  assign out_pair_second  = out_second_r;
  assign out_pair_count   = out_count_r;
  assign out_entries_used = out_used_r;

endmodule

/* src/pft_checker.sv */
// Port-level checker for the pair frequency table, bound to the top level.
module pft_checker
  import pft_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_pair_first,
  input logic [7:0]  out_pair_second,
  input logic [15:0] out_pair_count,
  input logic [6:0]  out_entries_used
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_pair_count) && $stable(out_entries_used))
    else $error("result beat changed while stalled");

  // Keys show only on a good read
  a_keys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_READ_OK) |->
      (out_pair_first == 8'd0) && (out_pair_second == 8'd0))
    else $error("keys nonzero outside a read");

  // No count on drop, bad read or clear
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_FULL) || (out_status == ST_READ_RANGE)
      || (out_status == ST_CLEARED)) |-> (out_pair_count == 16'd0))
    else $error("count nonzero on a status without an entry");

  // Clear empties the table, insert leaves a fresh entry
  a_clear_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status != ST_CLEARED) || (out_entries_used == 7'd0))
      && ((out_status != ST_INSERTED) || (out_pair_count == 16'd1)))
    else $error("clear or insert result inconsistent");

  // Saturation reports the ceiling
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SATURATED) |-> (out_pair_count == HIT_MAX))
    else $error("saturated result below ceiling");

endmodule

bind pair_frequency_table_top pft_checker u_pft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_pair_first   (out_pair_first),
  .out_pair_second  (out_pair_second),
  .out_pair_count   (out_pair_count),
  .out_entries_used (out_entries_used)
);

/* tb/tb.sv */
// Self-checking testbench for the pair frequency table top level.
module tb;
  import pft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action codes not named in the package
  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int IDLE_PERCENT  = 25;
  localparam int HIT_RUN       = 40;

  typedef struct {
    status_t     status;
    logic [7:0]  pair_first;
    logic [7:0]  pair_second;
    logic [15:0] pair_count;
    logic [6:0]  entries_used;
  } table_result_t;

  // Table predictor and store of expected results
  class pair_table_model;
    logic [7:0]    first_key [MAX_ENTRIES];
    logic [7:0]    second_key[MAX_ENTRIES];
    logic [15:0]   hits      [MAX_ENTRIES];
    int unsigned   used;
    int            errors;
    table_result_t pending_results[$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // Work out the result of one accepted beat and queue it
    function void note_request(logic [1:0] action, logic [7:0] k1, logic [7:0] k2,
                               logic [7:0] idx);
      table_result_t r;
      int unsigned   slot;
      bit            found;
      r.status       = ST_FULL;
      r.pair_first   = '0;
      r.pair_second  = '0;
      r.pair_count   = '0;
      found          = 1'b0;
      if (action[ACT_CLEAR_BIT]) begin
        used     = 0;
        r.status = ST_CLEARED;
      end else if (action == ACT_READ) begin
        if (idx < used) begin
          r.pair_first  = first_key[idx];
          r.pair_second = second_key[idx];
          r.pair_count  = hits[idx];
          r.status      = ST_READ_OK;
        end else begin
          r.status = ST_READ_RANGE;
        end
      end else begin
        // Search slots in insertion order, first match wins
        for (slot = 0; slot < used && !found; slot++) begin
          if (first_key[slot] == k1 && second_key[slot] == k2) begin
            found = 1'b1;
            if (hits[slot] != HIT_MAX) begin
              hits[slot] = hits[slot] + 16'd1;
              r.status   = ST_INCREMENTED;
            end else begin
              r.status = ST_SATURATED;
            end
            r.pair_count = hits[slot];
          end
        end
        // Append on a miss while room is left
        if (!found && used < MAX_ENTRIES) begin
          first_key[used]  = k1;
          second_key[used] = k2;
          hits[used]       = 16'd1;
          used             = used + 1;
          r.pair_count     = 16'd1;
          r.status         = ST_INSERTED;
        end
      end
      r.entries_used = used[6:0];
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result beat against the oldest expectation
    function void check_result(logic [2:0] status, logic [7:0] pf, logic [7:0] ps,
                               logic [15:0] cnt, logic [6:0] eu);
      table_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending: status %0d", status);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, status);
        errors++;
      end
      if (pf !== exp_r.pair_first) begin
        $error("pair_first: expected %0d, got %0d", exp_r.pair_first, pf);
        errors++;
      end
      if (ps !== exp_r.pair_second) begin
        $error("pair_second: expected %0d, got %0d", exp_r.pair_second, ps);
        errors++;
      end
      if (cnt !== exp_r.pair_count) begin
        $error("pair_count: expected %0d, got %0d", exp_r.pair_count, cnt);
        errors++;
      end
      if (eu !== exp_r.entries_used) begin
        $error("entries_used: expected %0d, got %0d", exp_r.entries_used, eu);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_key_first;
  logic [7:0]  in_key_second;
  logic [7:0]  in_entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_pair_first;
  logic [7:0]  out_pair_second;
  logic [15:0] out_pair_count;
  logic [6:0]  out_entries_used;

  bit              no_idle = 1'b0;
  int              stall_cycles = 0;
  pair_table_model table_model = new();

  pair_frequency_table_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_key_first     (in_key_first),
    .in_key_second    (in_key_second),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_pair_first   (out_pair_first),
    .out_pair_second  (out_pair_second),
    .out_pair_count   (out_pair_count),
    .out_entries_used (out_entries_used)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Randomly stall the result side
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      table_model.check_result(out_status, out_pair_first, out_pair_second,
                               out_pair_count, out_entries_used);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request beat and hold it until accepted
  task automatic send_request(logic [1:0] action, logic [7:0] k1, logic [7:0] k2,
                              logic [7:0] idx);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= action;
    in_key_first   <= k1;
    in_key_second  <= k2;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
    table_model.note_request(action, k1, k2, idx);
  endtask

  task automatic count_pair(logic [7:0] k1, logic [7:0] k2);
    send_request(ACT_COUNT, k1, k2, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_slot(logic [7:0] idx);
    send_request(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic clear_table(logic [1:0] code);
    send_request(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and hold off until every expected result has arrived
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int run_len;
    int pick;
    logic [7:0] kf;
    logic [7:0] ks;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_COUNT;
    in_key_first   = '0;
    in_key_second  = '0;
    in_entry_index = '0;
    out_ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes of keys, every action
    read_slot(8'd0);
    count_pair(8'd0, 8'd0);
    count_pair(8'd255, 8'd255);
    count_pair(8'd0, 8'd0);
    count_pair(8'd0, 8'd255);
    count_pair(8'd255, 8'd0);
    read_slot(8'd0);
    read_slot(8'd3);
    read_slot(8'd4);
    read_slot(8'd255);
    clear_table(ACT_SPARE);
    read_slot(8'd0);
    clear_table(ACT_CLEAR);

    // Fill the table, then miss while full and hit the last slot
    for (int n = 0; n < MAX_ENTRIES; n++) begin
      count_pair(8'(n), 8'(255 - n));
    end
    count_pair(8'd1, 8'd1);
    count_pair(8'(MAX_ENTRIES - 1), 8'(256 - MAX_ENTRIES));
    read_slot(8'(MAX_ENTRIES - 1));
    read_slot(8'(MAX_ENTRIES));
    wait_for_drain();
    clear_table(ACT_CLEAR);

    // Hammer one pair back to back, no idling
    no_idle = 1'b1;
    for (int n = 0; n < HIT_RUN; n++) begin
      count_pair(8'hA5, 8'h5A);
    end
    read_slot(8'd0);
    no_idle = 1'b0;

    // Random: runs of counts and reads between clears
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(10, 160);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        no_idle = (sent >= 700 && sent < 1000);
        if (sent % 300 == 299) begin
          wait_for_drain();
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 22) begin
          read_slot(8'($urandom_range(0, 99) < 70 ? $urandom_range(0, 66)
                                                  : $urandom_range(0, 255)));
        end else begin
          // Mostly a small pool of pairs so hits and a full table occur
          if ($urandom_range(0, 99) < 75) begin
            kf = 8'($urandom_range(0, 11));
            ks = 8'($urandom_range(0, 7));
          end else begin
            kf = 8'($urandom_range(0, 255));
            ks = 8'($urandom_range(0, 255));
          end
          count_pair(kf, ks);
        end
        sent++;
      end
      clear_table($urandom_range(0, 1) ? ACT_CLEAR : ACT_SPARE);
      sent++;
    end
    no_idle = 1'b0;

    // Drain and let the block settle
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
